// ===== sv/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// Sizes, opcode and status codes for the scan line interval set.
// ----------------------------------------------------------------------------
package sis_pkg;

  // Largest number of runs one scan line can hold, and the column width.
  localparam int MAX_RUNS   = 32;
  localparam int COORD_BITS = 16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SUB   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_UNDEF = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

endpackage

// ===== sv/scanline_interval_set.sv =====
// ----------------------------------------------------------------------------
// scanline_interval_set
// One scan line of a mask kept as a sorted list of disjoint column runs.
// ----------------------------------------------------------------------------
// Usage: raise start with in_opcode, in_run_start, in_run_end and
// in_read_index while busy is low; the command transfers at that edge.
// An add merges the run into the list, a subtract removes its columns
// (trimming or splitting runs), and a read returns the run at an index.
// Every command gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall, so results are never held.
//
// The list lives in two synchronous memories: the stored table and a work
// table. An add or subtract reads the stored table one entry per cycle,
// pausing when a split or an insertion needs a second work write, and
// writes the new list into the work table, then copies the work table
// back one entry per cycle. Busy stays high until the result is shown.
// On overflow the copy back is skipped, so the stored list is unchanged.
// Reset clears the run count and control state; memory content is not
// cleared, since entries at or beyond the run count are never used.
// ----------------------------------------------------------------------------
module scanline_interval_set
  import sis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [COORD_BITS-1:0] in_run_start,
  input  logic [COORD_BITS-1:0] in_run_end,
  input  logic [4:0]            in_read_index,
  output logic                  out_valid,
  output logic [5:0]            out_run_count,
  output logic [1:0]            out_status,
  output logic [COORD_BITS-1:0] out_start,
  output logic [COORD_BITS-1:0] out_end
);

  localparam int IW  = $clog2(MAX_RUNS);
  localparam int CW  = $clog2(MAX_RUNS + 1);
  // The work list may grow to MAX_RUNS + 1 before overflow is known.
  localparam int NW  = $clog2(MAX_RUNS + 2);
  localparam int XW  = COORD_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_WAIT, S_SCAN, S_PEND, S_TAIL, S_CHECK, S_COPY, S_DONE
  } state_t;

  typedef logic [2*COORD_BITS-1:0] entry_t;

  entry_t run_mem  [MAX_RUNS];
  entry_t work_mem [MAX_RUNS];

  state_t                state_r;
  logic [CW-1:0]         total_r;
  logic [1:0]            op_r;
  logic [XW-1:0]         s_r, e_r, ms_r, me_r;
  logic                  placed_r;
  logic [CW-1:0]         idx_r;
  logic [NW-1:0]         n_r;
  logic [1:0]            status_r;
  logic [COORD_BITS-1:0] os_r, oe_r;
  logic                  valid_r;
  entry_t                run_rd_r, work_rd_r;
  // Second entry of a split, or the stored run that follows an insertion.
  entry_t                pend_d_r;

  // Memory ports, driven from the sequencer.
  logic                  run_re, run_we, work_re, work_we;
  logic [IW-1:0]         run_ra, run_wa, work_ra, work_wa;
  entry_t                run_wd, work_wd;

  // Per-entry decision on the stored entry held in run_rd_r.
  logic [XW-1:0]         rs, re;
  logic                  push, pend;
  entry_t                push_d, pend_d;
  logic [XW-1:0]         ms_nxt, me_nxt;
  logic                  placed_nxt;

  logic                  scan_next;
  logic                  n_room;

  function automatic entry_t pack(input logic [XW-1:0] a, input logic [XW-1:0] b);
    pack = {a[COORD_BITS-1:0], b[COORD_BITS-1:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (run_re) run_rd_r <= run_mem[run_ra];
    if (run_we) run_mem[run_wa] <= run_wd;
  end

  always_ff @(posedge clk) begin
    if (work_re) work_rd_r <= work_mem[work_ra];
    if (work_we) work_mem[work_wa] <= work_wd;
  end

  // Stored entry under scan, widened by one bit for the +1 compares.
  assign rs = {1'b0, run_rd_r[2*COORD_BITS-1:COORD_BITS]};
  assign re = {1'b0, run_rd_r[COORD_BITS-1:0]};

  // Another stored entry follows the one under scan.
  assign scan_next = (idx_r + CW'(1)) < total_r;
  // Work table writes stop at its depth; the count still runs on so that
  // overflow is seen.
  assign n_room    = n_r < NW'(MAX_RUNS);

  always_comb begin
    push       = 1'b0;
    pend       = 1'b0;
    push_d     = run_rd_r;
    pend_d     = run_rd_r;
    ms_nxt     = ms_r;
    me_nxt     = me_r;
    placed_nxt = placed_r;
    if (op_r == OP_ADD) begin
      if (re + XW'(1) < s_r) begin
        push = 1'b1;
      end else if (rs > e_r + XW'(1)) begin
        push = 1'b1;
        if (!placed_r) begin
          // The merged run goes first; the stored run follows next cycle.
          push_d     = pack(ms_r, me_r);
          pend       = 1'b1;
          placed_nxt = 1'b1;
        end
      end else begin
        if (rs < ms_r) ms_nxt = rs;
        if (re > me_r) me_nxt = re;
      end
    end else begin
      if (re < s_r || rs > e_r) begin
        push = 1'b1;
      end else if (rs < s_r) begin
        push   = 1'b1;
        push_d = pack(rs, s_r - XW'(1));
        if (re > e_r) begin
          pend   = 1'b1;
          pend_d = pack(e_r + XW'(1), re);
        end
      end else if (re > e_r) begin
        push   = 1'b1;
        push_d = pack(e_r + XW'(1), re);
      end
    end
  end

  always_comb begin
    run_re  = 1'b0;
    run_ra  = IW'(idx_r + CW'(1));
    run_we  = 1'b0;
    run_wa  = idx_r[IW-1:0];
    run_wd  = work_rd_r;
    work_re = 1'b0;
    work_ra = IW'(idx_r + CW'(1));
    work_we = 1'b0;
    work_wa = n_r[IW-1:0];
    work_wd = push_d;
    unique case (state_r)
      S_IDLE: begin
        // A read fetches its entry; an add or subtract fetches entry 0.
        run_re = start;
        run_ra = (in_opcode == OP_READ) ? IW'(in_read_index) : '0;
      end
      S_SCAN: begin
        // Fetch the next stored entry while deciding on this one.
        run_re  = scan_next;
        work_we = push && n_room;
      end
      S_PEND: begin
        work_we = n_room;
        work_wd = pend_d_r;
      end
      S_TAIL: begin
        work_we = (op_r == OP_ADD) && !placed_r && n_room;
        work_wd = pack(ms_r, me_r);
      end
      S_CHECK: begin
        work_re = 1'b1;
        work_ra = '0;
      end
      S_COPY: begin
        // Write back entry idx_r while fetching the following one.
        run_we  = 1'b1;
        work_re = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r     <= in_opcode;
            s_r      <= {1'b0, in_run_start};
            e_r      <= {1'b0, in_run_end};
            ms_r     <= {1'b0, in_run_start};
            me_r     <= {1'b0, in_run_end};
            placed_r <= 1'b0;
            idx_r    <= (in_opcode == OP_READ) ? CW'(in_read_index) : '0;
            n_r      <= '0;
            status_r <= ST_OK;
            os_r     <= '0;
            oe_r     <= '0;
            priority if (in_opcode == OP_READ) begin
              state_r <= S_RD_WAIT;
            end else if ((in_opcode == OP_ADD || in_opcode == OP_SUB) &&
                         in_run_end >= in_run_start) begin
              state_r <= (total_r == '0) ? S_TAIL : S_SCAN;
            end else begin
              // A reversed run or an unknown opcode changes nothing.
              state_r <= S_DONE;
            end
          end
        end
        S_RD_WAIT: begin
          if (idx_r < total_r) begin
            os_r <= run_rd_r[2*COORD_BITS-1:COORD_BITS];
            oe_r <= run_rd_r[COORD_BITS-1:0];
          end else begin
            status_r <= ST_RANGE;
          end
          state_r <= S_DONE;
        end
        S_SCAN: begin
          ms_r     <= ms_nxt;
          me_r     <= me_nxt;
          placed_r <= placed_nxt;
          if (push) n_r <= n_r + NW'(1);
          idx_r    <= idx_r + CW'(1);
          priority if (pend) begin
            pend_d_r <= pend_d;
            state_r  <= S_PEND;
          end else if (!scan_next) begin
            state_r <= S_TAIL;
          end
        end
        S_PEND: begin
          n_r     <= n_r + NW'(1);
          state_r <= (idx_r < total_r) ? S_SCAN : S_TAIL;
        end
        S_TAIL: begin
          if (op_r == OP_ADD && !placed_r) n_r <= n_r + NW'(1);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          priority if (n_r > NW'(MAX_RUNS)) begin
            status_r <= ST_OVERFLOW;
            state_r  <= S_DONE;
          end else if (n_r == '0) begin
            total_r <= '0;
            state_r <= S_DONE;
          end else begin
            idx_r   <= '0;
            state_r <= S_COPY;
          end
        end
        S_COPY: begin
          if ((idx_r + CW'(1)) < CW'(n_r)) begin
            idx_r <= idx_r + CW'(1);
          end else begin
            total_r <= CW'(n_r);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = valid_r;
  assign out_run_count = 6'(total_r);
  assign out_status    = status_r;
  assign out_start     = os_r;
  assign out_end       = oe_r;

  // A result only appears once the block is idle again.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy);

  // Each result is strobed for a single cycle.
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid);

  // An accepted command always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy);

  // The stored run count never exceeds the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_run_count <= 6'(MAX_RUNS));

endmodule

// ===== verif/scanline_checker.sv =====
// ----------------------------------------------------------------------------
// scanline_checker
// Watches the command and result transfers of the scan line interval set,
// keeps its own copy of the run list, and compares every result with the
// oldest expected one.
// ----------------------------------------------------------------------------
module scanline_checker
  import sis_pkg::*;
#(
  parameter int RUN_CAP = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_run_start,
  input  logic [15:0] in_run_end,
  input  logic [4:0]  in_read_index,
  input  logic        out_valid,
  input  logic [5:0]  out_run_count,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_start,
  input  logic [15:0] out_end,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [5:0]  count;
    logic [1:0]  status;
    logic [15:0] first_col;
    logic [15:0] last_col;
  } line_result_t;

  logic [15:0] run_lo [RUN_CAP];
  logic [15:0] run_hi [RUN_CAP];
  int          run_num;
  line_result_t expected_q [$];

  assign pending = expected_q.size();

  // Rebuilds the list into scratch arrays and keeps it only if it fits.
  function automatic line_result_t apply_command(logic [1:0] op, logic [15:0] s,
                                                 logic [15:0] e, logic [4:0] idx);
    line_result_t r;
    logic [15:0] new_lo [RUN_CAP + 2];
    logic [15:0] new_hi [RUN_CAP + 2];
    int n;
    int ms;
    int me;
    bit placed;
    r = '0;
    n = 0;
    ms = int'(s);
    me = int'(e);
    placed = 0;
    if ((op == OP_ADD || op == OP_SUB) && e >= s) begin
      for (int i = 0; i < run_num; i++) begin
        if (op == OP_ADD) begin
          if (int'(run_hi[i]) + 1 < int'(s)) begin
            new_lo[n] = run_lo[i]; new_hi[n] = run_hi[i]; n++;
          end else if (int'(run_lo[i]) > int'(e) + 1) begin
            if (!placed) begin
              if (n < RUN_CAP + 2) begin
                new_lo[n] = ms[15:0]; new_hi[n] = me[15:0];
              end
              n++;
              placed = 1;
            end
            if (n < RUN_CAP + 2) begin
              new_lo[n] = run_lo[i]; new_hi[n] = run_hi[i];
            end
            n++;
          end else begin
            if (int'(run_lo[i]) < ms) ms = int'(run_lo[i]);
            if (int'(run_hi[i]) > me) me = int'(run_hi[i]);
          end
        end else begin
          if (run_hi[i] < s || run_lo[i] > e) begin
            if (n < RUN_CAP + 2) begin
              new_lo[n] = run_lo[i]; new_hi[n] = run_hi[i];
            end
            n++;
          end else begin
            if (run_lo[i] < s) begin
              if (n < RUN_CAP + 2) begin
                new_lo[n] = run_lo[i]; new_hi[n] = s - 16'd1;
              end
              n++;
            end
            if (run_hi[i] > e) begin
              if (n < RUN_CAP + 2) begin
                new_lo[n] = e + 16'd1; new_hi[n] = run_hi[i];
              end
              n++;
            end
          end
        end
      end
      if (op == OP_ADD && !placed) begin
        if (n < RUN_CAP + 2) begin
          new_lo[n] = ms[15:0]; new_hi[n] = me[15:0];
        end
        n++;
      end
      if (n > RUN_CAP) begin
        r.status = ST_OVERFLOW;
      end else begin
        for (int i = 0; i < n; i++) begin
          run_lo[i] = new_lo[i];
          run_hi[i] = new_hi[i];
        end
        run_num = n;
      end
    end else if (op == OP_READ) begin
      if (int'(idx) < run_num) begin
        r.first_col = run_lo[idx];
        r.last_col = run_hi[idx];
      end else begin
        r.status = ST_RANGE;
      end
    end
    r.count = run_num[5:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (!rst_n) begin
      run_num = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, run_count", int'(out_run_count), -1);
        end else begin
          want = expected_q.pop_front();
          if (out_run_count !== want.count)
            report_mismatch("run_count", int'(out_run_count), int'(want.count));
          if (out_status !== want.status)
            report_mismatch("status", int'(out_status), int'(want.status));
          if (out_start !== want.first_col)
            report_mismatch("out_start", int'(out_start), int'(want.first_col));
          if (out_end !== want.last_col)
            report_mismatch("out_end", int'(out_end), int'(want.last_col));
        end
      end
      if (start && !busy)
        expected_q.push_back(apply_command(in_opcode, in_run_start, in_run_end,
                                           in_read_index));
    end
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the scan line interval set with directed and random commands and
// reports whether the checker saw any mismatch.
// ----------------------------------------------------------------------------
module tb
  import sis_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [15:0] in_run_start;
  logic [15:0] in_run_end;
  logic [4:0]  in_read_index;
  logic        out_valid;
  logic [5:0]  out_run_count;
  logic [1:0]  out_status;
  logic [15:0] out_start;
  logic [15:0] out_end;
  int          fail_count;
  int          pending;
  int          sent;

  scanline_interval_set dut (.*);

  scanline_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // This timeout leaves a wide margin over the slowest correct run, idle gaps included.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  // Drives one command and holds it until the transfer happens. The sender
  // idles first on about 28 of a hundred commands unless quiet is set.
  task automatic send_command(logic [1:0] op, logic [15:0] s, logic [15:0] e,
                              logic [4:0] idx, bit quiet);
    if (!quiet) begin
      while ($urandom_range(99) < 28) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_opcode <= op;
    in_run_start <= s;
    in_run_end <= e;
    in_read_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Random command over a chosen column span; small spans keep the list
  // crowded so that overflow and splits happen often.
  task automatic send_random(bit quiet, int span);
    logic [15:0] s;
    logic [15:0] e;
    int pick;
    logic [1:0] op;
    pick = $urandom_range(99);
    s = 16'($urandom_range(span));
    e = 16'(s + $urandom_range(span / 16 + 1));
    if (pick < 45) op = OP_ADD;
    else if (pick < 70) op = OP_SUB;
    else if (pick < 95) op = OP_READ;
    else op = OP_UNDEF;
    // Some commands span the whole field range or are reversed.
    if ($urandom_range(19) == 0) begin
      s = 16'($urandom);
      e = 16'($urandom);
    end
    send_command(op, s, e, 5'($urandom_range(31)), quiet);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ADD;
    in_run_start = '0;
    in_run_end = '0;
    in_read_index = '0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty reads, extremes, adjacency, splits, reversed runs,
    // the unknown opcode and overflow of the list.
    send_command(OP_READ, 16'd0, 16'd0, 5'd0, 1);
    send_command(OP_ADD, 16'd0, 16'd0, 5'd31, 1);
    send_command(OP_ADD, 16'hFFFF, 16'hFFFF, 5'd0, 1);
    send_command(OP_ADD, 16'd2, 16'd5, 5'd0, 1);
    send_command(OP_ADD, 16'd1, 16'd1, 5'd0, 1);
    send_command(OP_READ, 16'd0, 16'd0, 5'd0, 1);
    send_command(OP_READ, 16'd0, 16'd0, 5'd1, 1);
    send_command(OP_SUB, 16'd3, 16'd3, 5'd0, 1);
    send_command(OP_READ, 16'd0, 16'd0, 5'd1, 1);
    send_command(OP_ADD, 16'd9, 16'd4, 5'd0, 1);
    send_command(OP_SUB, 16'd9, 16'd4, 5'd0, 1);
    send_command(OP_UNDEF, 16'hFFFF, 16'hFFFF, 5'd31, 1);
    send_command(OP_SUB, 16'd0, 16'hFFFF, 5'd0, 1);
    send_command(OP_READ, 16'd0, 16'd0, 5'd31, 1);
    for (int i = 0; i < 33; i++)
      send_command(OP_ADD, 16'(i * 4), 16'(i * 4 + 1), 5'd0, 1);
    send_command(OP_READ, 16'd0, 16'd0, 5'd31, 1);
    send_command(OP_SUB, 16'd40, 16'd40, 5'd0, 1);
    send_command(OP_ADD, 16'd0, 16'hFFFF, 5'd0, 1);

    // Random part: a stretch with no idling, then idling throughout.
    for (int i = 0; i < 200; i++) send_random(1, 255);
    // Let the block drain completely before carrying on.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    for (int i = 0; i < 800; i++)
      send_random(0, (i % 4 == 0) ? 65535 : 400);
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
